/* rtl/core/length_prefix_deframer_unit_macros.svh */
// assertion macros for the length-prefix deframer checker
// no dependencies; taken in by the checker file
`ifndef LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define LPD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LPD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/lpd_pkg.sv */
// shared constants and types of the length-prefix deframer
// no dependencies
`default_nettype none

package lpd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned HCOUNT_W     = 3;
  localparam int unsigned CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TRANSFER_UNIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIVER_LIMIT     = 2'd1;

  localparam logic [LEN_W-1:0] MTU_RESET   = 32'h0001_0000;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

  // last header position, widened so that eight header bytes still fit
  localparam logic [HCOUNT_W:0] HEADER_LAST = (HCOUNT_W + 1)'(HEADER_BYTES - 1);

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_of_packet;
    logic              empty_packet;
    logic              length_error;
    logic              truncated;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/lpd_byte_if.sv */
// stream channels and configuration write channel of the deframer
// depends on lpd_pkg
`default_nettype none

interface lpd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [lpd_pkg::DATA_W-1:0]   in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpd_result_if;
  logic                         valid;
  logic                         ready;
  logic [lpd_pkg::DATA_W-1:0]   data_byte;
  logic                         last_of_packet;
  logic                         empty_packet;
  logic                         length_error;
  logic                         truncated;
  modport source (output valid, output data_byte, output last_of_packet,
                  output empty_packet, output length_error, output truncated,
                  input ready);
  modport sink (input valid, input data_byte, input last_of_packet,
                input empty_packet, input length_error, input truncated,
                output ready);
endinterface

interface lpd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lpd_pkg::CFG_INDEX_W-1:0]   reg_index;
  logic [lpd_pkg::LEN_W-1:0]         wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/core/length_prefix_deframer_unit.sv */
// length-prefix deframer: splits a byte stream into packets led by a
// little-endian length; depends on lpd_pkg and the channel interfaces
//
//   channel       role    carries
//   byte_stream   sink    in_byte, one raw stream byte per request
//   packet_stream source  data_byte and the four packet flags
//   cfg           sink    reg_index, wdata (register writes, always ready)
//
// a byte passes the input register, then the header/payload step into the
// result register
// one byte per cycle sustained while results are taken; the step is a 32-bit add and the length and limit compares
// rst is synchronous: clears control state and valid flags, loads config reset values
// a stalled result holds its stage; the input stage refills as it drains
`default_nettype none

module length_prefix_deframer_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  lpd_byte_if.sink     byte_stream,
  lpd_result_if.source packet_stream,
  lpd_cfg_if.sink      cfg
);

  logic [lpd_pkg::LEN_W-1:0]    max_transfer_unit;
  logic [lpd_pkg::LEN_W-1:0]    deliver_limit;

  logic                         in_valid;
  logic [lpd_pkg::DATA_W-1:0]   in_data;

  logic [lpd_pkg::HCOUNT_W-1:0] header_count;
  logic [lpd_pkg::LEN_W-1:0]    packet_length;
  logic [lpd_pkg::LEN_W-1:0]    payload_count;
  logic                         error_sticky;
  logic                         in_payload;

  logic [lpd_pkg::HCOUNT_W-1:0] header_count_next;
  logic [lpd_pkg::LEN_W-1:0]    packet_length_next;
  logic [lpd_pkg::LEN_W-1:0]    payload_count_next;
  logic                         error_sticky_next;
  logic                         in_payload_next;

  logic                         out_valid;
  lpd_pkg::result_t             result;
  lpd_pkg::result_t             result_next;
  logic                         emit;

  logic                         out_free;
  logic                         step;

  logic [lpd_pkg::LEN_W-1:0]    len_base;
  logic [lpd_pkg::LEN_W-1:0]    len_gather;
  logic [lpd_pkg::LEN_W-1:0]    count_inc;
  logic [lpd_pkg::HCOUNT_W:0]   pos_wide;
  logic                         header_done;
  logic                         pkt_final;
  logic                         within_limit;

  assign out_free          = !out_valid || packet_stream.ready;
  assign step              = in_valid && out_free;
  assign byte_stream.ready = !in_valid || out_free;
  assign cfg.ready         = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_transfer_unit <= lpd_pkg::MTU_RESET;
      deliver_limit     <= lpd_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        lpd_pkg::REG_MAX_TRANSFER_UNIT: max_transfer_unit <= cfg.wdata;
        lpd_pkg::REG_DELIVER_LIMIT:     deliver_limit     <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      in_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.ready && byte_stream.valid) begin
      in_data <= byte_stream.in_byte;
    end
  end

  // header gathering
  always_comb begin
    pos_wide    = {1'b0, header_count};
    header_done = (pos_wide >= lpd_pkg::HEADER_LAST);
    len_base    = (header_count == '0) ? '0 : packet_length;
    if (header_count < 3'd4) begin
      len_gather = len_base |
                   ({{(lpd_pkg::LEN_W - lpd_pkg::DATA_W){1'b0}}, in_data}
                    << {header_count[1:0], 3'b000});
    end else if (in_data != '0) begin
      len_gather = '1;
    end else begin
      len_gather = len_base;
    end
    count_inc    = payload_count + 32'd1;
    pkt_final    = (count_inc >= packet_length);
    within_limit = (count_inc <= deliver_limit);
  end

  // one step per byte
  always_comb begin
    header_count_next  = header_count;
    packet_length_next = packet_length;
    payload_count_next = payload_count;
    error_sticky_next  = error_sticky;
    in_payload_next    = in_payload;
    emit               = 1'b0;
    result_next        = '0;
    priority if (error_sticky) begin
      emit = 1'b0;
    end else if (!in_payload) begin
      packet_length_next = len_gather;
      if (header_done) begin
        header_count_next  = '0;
        payload_count_next = '0;
        if (len_gather > max_transfer_unit) begin
          error_sticky_next        = 1'b1;
          emit                     = 1'b1;
          result_next.length_error = 1'b1;
        end else if (len_gather == '0) begin
          emit                       = 1'b1;
          result_next.last_of_packet = 1'b1;
          result_next.empty_packet   = 1'b1;
        end else begin
          in_payload_next = 1'b1;
        end
      end else begin
        header_count_next = header_count + 3'd1;
      end
    end else begin
      payload_count_next = count_inc;
      if (pkt_final) begin
        in_payload_next    = 1'b0;
        header_count_next  = '0;
        payload_count_next = '0;
      end
      if (within_limit) begin
        emit                       = 1'b1;
        result_next.data_byte      = in_data;
        result_next.last_of_packet = pkt_final;
      end else if (pkt_final) begin
        emit                       = 1'b1;
        result_next.last_of_packet = 1'b1;
        result_next.truncated      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      packet_length <= '0;
      payload_count <= '0;
      error_sticky  <= 1'b0;
      in_payload    <= 1'b0;
    end else if (step) begin
      header_count  <= header_count_next;
      packet_length <= packet_length_next;
      payload_count <= payload_count_next;
      error_sticky  <= error_sticky_next;
      in_payload    <= in_payload_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result <= result_next;
    end
  end

  assign packet_stream.valid          = out_valid;
  assign packet_stream.data_byte      = result.data_byte;
  assign packet_stream.last_of_packet = result.last_of_packet;
  assign packet_stream.empty_packet   = result.empty_packet;
  assign packet_stream.length_error   = result.length_error;
  assign packet_stream.truncated      = result.truncated;

endmodule

`default_nettype wire

/* rtl/core/lpd_checker.sv */
// port-level checks for the length-prefix deframer, bound to its top level
// depends on lpd_pkg and length_prefix_deframer_unit_macros.svh
`default_nettype none

`include "length_prefix_deframer_unit_macros.svh"

module lpd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [lpd_pkg::DATA_W-1:0] data_byte,
  input wire logic                       last_of_packet,
  input wire logic                       empty_packet,
  input wire logic                       length_error,
  input wire logic                       truncated
);

  `LPD_ASSERT_IMPLIES(a_stall_hold, clk, rst, !$past(rst) && $past(out_valid && !out_ready), out_valid && $stable(data_byte) && $stable(last_of_packet), "stalled result changed")
  `LPD_ASSERT_IMPLIES(a_error_marker, clk, rst, out_valid && length_error, !last_of_packet && data_byte == '0 && !empty_packet && !truncated, "bad error marker")
  `LPD_ASSERT_IMPLIES(a_marker_ends, clk, rst, out_valid && (empty_packet || truncated), last_of_packet && data_byte == '0 && !(empty_packet && truncated), "bad packet marker")
  `LPD_ASSERT_IMPLIES(a_error_sticky, clk, rst, !$past(rst) && $past(out_valid && out_ready && length_error), !out_valid, "result after length error")

endmodule

bind length_prefix_deframer_unit lpd_checker u_lpd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (packet_stream.valid),
  .out_ready      (packet_stream.ready),
  .data_byte      (packet_stream.data_byte),
  .last_of_packet (packet_stream.last_of_packet),
  .empty_packet   (packet_stream.empty_packet),
  .length_error   (packet_stream.length_error),
  .truncated      (packet_stream.truncated)
);

`default_nettype wire
